[hdl/ffwa_pkg.sv]
// package: types and constants for the first-fit wavelength assigner
package ffwa_pkg;
  localparam int NUM_NODES = 16;
  localparam int NUM_CORES = 8;
  localparam int NUM_WAVELENGTHS = 64;
  localparam int MAX_HOPS = 16;
  localparam int NODE_W = 4;
  localparam int CORE_W = 3;
  localparam int WAVE_W = 6;
  localparam int HOP_IDX_W = 4;
  localparam int HOP_CNT_W = 5;
  localparam int WORD_W = 64;
  localparam int ADDR_W = 2 * NODE_W + CORE_W;
  localparam int DEPTH = NUM_NODES * NUM_NODES * NUM_CORES;
  localparam int CLR_W = ADDR_W + 1;

  localparam logic [0:0] CFG_CORES = 1'b0;
  localparam logic [0:0] CFG_WAVES = 1'b1;

  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [NODE_W-1:0]     from_node;
    logic [NODE_W-1:0]     to_node;
    logic                  last_hop;
    logic [CORE_W-1:0]     release_core;
    logic [WAVE_W-1:0]     release_wavelength;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CORE_W-1:0] granted_core;
    logic [WAVE_W-1:0] granted_wavelength;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_RELEASE = 2'd0,
    OP_ROUTE   = 2'd1,
    OP_REJECT  = 2'd2
  } op_t;

  // command from front to back
  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [CORE_W-1:0] core;
    logic [WAVE_W-1:0] wave;
    logic [HOP_CNT_W-1:0] hops;
  } cmd_t;
endpackage

[hdl/ffwa_front.sv]
// front: hop buffering and classification into commands
module ffwa_front import ffwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd,
  input  logic                 route_busy,
  input  logic [HOP_IDX_W-1:0] hop_rd_idx,
  output logic [2*NODE_W-1:0]  hop_rd_data
);
  logic [2*NODE_W-1:0] hop_mem [MAX_HOPS];
  logic [2*NODE_W-1:0] hop_rd_r;
  logic [HOP_CNT_W-1:0] hop_count_r, hop_count_nxt;
  logic overflow_r, overflow_nxt;
  logic take, is_req, is_last;

  // queue stage holding one command
  logic q_valid_r;
  cmd_t q_r;

  assign is_req = in_data.kind == KIND_REQUEST;
  assign is_last = is_req && in_data.last_hop;
  // hop buffer is read by back during a route, so hold new request hops
  assign in_ready = (!q_valid_r || cmd_ready) && !(is_req && route_busy);
  assign take = in_valid && in_ready;
  assign cmd_valid = q_valid_r;
  assign cmd = q_r;
  assign hop_rd_data = hop_rd_r;

  always_comb begin
    hop_count_nxt = hop_count_r;
    overflow_nxt = overflow_r;
    if (take && is_req) begin
      if (is_last) begin
        hop_count_nxt = '0;
        overflow_nxt = 1'b0;
      end else if (hop_count_r < HOP_CNT_W'(MAX_HOPS)) begin
        hop_count_nxt = hop_count_r + 1'b1;
      end else begin
        overflow_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_req && hop_count_r < HOP_CNT_W'(MAX_HOPS)) begin
      hop_mem[hop_count_r[HOP_IDX_W-1:0]] <= {in_data.from_node, in_data.to_node};
    end
    hop_rd_r <= hop_mem[hop_rd_idx];
    if (take) begin
      q_r.from_node <= in_data.from_node;
      q_r.to_node <= in_data.to_node;
      q_r.core <= in_data.release_core;
      q_r.wave <= in_data.release_wavelength;
      if (hop_count_r < HOP_CNT_W'(MAX_HOPS)) begin
        q_r.hops <= hop_count_r + 1'b1;
      end else begin
        q_r.hops <= hop_count_r;
      end
      if (!is_req) begin
        q_r.op <= OP_RELEASE;
      end else if (overflow_r || hop_count_r >= HOP_CNT_W'(MAX_HOPS)) begin
        q_r.op <= OP_REJECT;
      end else begin
        q_r.op <= OP_ROUTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_count_r <= '0;
      overflow_r <= 1'b0;
      q_valid_r <= 1'b0;
    end else begin
      hop_count_r <= hop_count_nxt;
      overflow_r <= overflow_nxt;
      if (take && (!is_req || is_last)) begin
        q_valid_r <= 1'b1;
      end else if (cmd_ready) begin
        q_valid_r <= 1'b0;
      end
    end
  end
endmodule

[hdl/ffwa_back.sv]
// back: occupancy store, first-fit search, marking and releases
module ffwa_back import ffwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  input  logic [CORE_W:0]      n_cores,
  input  logic [WAVE_W:0]      n_waves,
  output logic                 route_busy,
  output logic [HOP_IDX_W-1:0] hop_rd_idx,
  input  logic [2*NODE_W-1:0]  hop_rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RL_RD  = 10'b0000000100,
    S_RL_WR  = 10'b0000001000,
    S_HOP    = 10'b0000010000,
    S_ACC    = 10'b0000100000,
    S_PICK   = 10'b0001000000,
    S_MK_RD  = 10'b0010000000,
    S_MK_WR  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic wr_en, rd_en;
  logic [CLR_W-1:0] clr_r;
  cmd_t cmd_r;
  logic [CORE_W-1:0] core_r;
  logic [HOP_CNT_W-1:0] hop_r, hop_nxt;
  logic [WORD_W-1:0] free_r, mask;
  logic link_bad_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WAVE_W-1:0] wave_r;
  logic [WAVE_W-1:0] first_w;
  logic [CORE_W:0] eff_cores;
  logic last_core, out_free;
  logic ovalid_r;
  out_item_t odata_r, res_r;

  assign eff_cores = (n_cores > (CORE_W+1)'(NUM_CORES)) ? (CORE_W+1)'(NUM_CORES) : n_cores;
  assign last_core = (CORE_W+1)'(core_r) + 1'b1 >= eff_cores;
  assign out_free = !ovalid_r || out_ready;
  always_comb begin
    mask = '0;
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (WAVE_W+1)'(i) < n_waves && i < NUM_WAVELENGTHS;
    end
  end
  always_comb begin
    first_w = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_r[i]) first_w = WAVE_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign cmd_ready = state_r == S_IDLE;
  assign route_busy = state_r != S_IDLE || (cmd_valid && cmd.op == OP_ROUTE);
  // hop buffer read is registered, so ask for the index of the next cycle
  assign hop_rd_idx = hop_nxt[HOP_IDX_W-1:0];
  assign out_valid = ovalid_r;
  assign out_data = odata_r;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = addr_r;
    wr_en = 1'b0;
    wr_addr = addr_r;
    wr_data = rd_q;
    state_nxt = state_r;
    hop_nxt = hop_r;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_r[ADDR_W-1:0];
        wr_data = '0;
        hop_nxt = '0;
        if (clr_r == CLR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        hop_nxt = '0;
        if (cmd_valid) begin
          case (cmd.op)
            OP_RELEASE: state_nxt = S_RL_RD;
            OP_ROUTE: state_nxt = (eff_cores == '0) ? S_OUT : S_HOP;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RL_RD: begin
        rd_en = 1'b1;
        state_nxt = S_RL_WR;
      end
      S_RL_WR: begin
        wr_en = !link_bad_r;
        wr_data = rd_q & ~(WORD_W'(1) << wave_r);
        state_nxt = S_IDLE;
      end
      S_HOP: begin
        rd_en = 1'b1;
        rd_addr = {hop_rd_data, core_r};
        hop_nxt = hop_r + 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: state_nxt = (hop_r == cmd_r.hops) ? S_PICK : S_HOP;
      S_PICK: begin
        hop_nxt = '0;
        if (free_r != '0) state_nxt = S_MK_RD;
        else if (last_core) state_nxt = S_OUT;
        else state_nxt = S_HOP;
      end
      S_MK_RD: begin
        rd_en = 1'b1;
        rd_addr = {hop_rd_data, core_r};
        hop_nxt = hop_r + 1'b1;
        state_nxt = S_MK_WR;
      end
      S_MK_WR: begin
        wr_en = 1'b1;
        wr_data = rd_q | (WORD_W'(1) << wave_r);
        state_nxt = (hop_r == cmd_r.hops) ? S_OUT : S_MK_RD;
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) odata_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      hop_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hop_r <= hop_nxt;
      if (state_r == S_OUT && out_free) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          cmd_r <= cmd;
          core_r <= '0;
          free_r <= mask;
          link_bad_r <= 1'b0;
          addr_r <= {cmd.from_node, cmd.to_node, cmd.core};
          wave_r <= cmd.wave;
          res_r <= {(cmd.op == OP_REJECT) ? ST_TOO_LONG : ST_BLOCKED,
                    CORE_W'(0), WAVE_W'(0)};
        end
        S_HOP: addr_r <= {hop_rd_data, core_r};
        S_ACC: free_r <= free_r & ~rd_q;
        S_PICK: begin
          if (free_r != '0) begin
            wave_r <= first_w;
            res_r <= {ST_GRANTED, core_r, first_w};
          end else if (!last_core) begin
            core_r <= core_r + 1'b1;
            free_r <= mask;
          end
        end
        S_MK_RD: addr_r <= {hop_rd_data, core_r};
        default: ;
      endcase
    end
  end
endmodule

[hdl/first_fit_core_wavelength_assigner_unit.sv]
// top level: first-fit core and wavelength assigner
// The last hop of a request searches the cores in turn, reading the occupancy word of every hop for
// each core searched, then marks the granted slot on every hop and hands over the beat; other request
// hops are only buffered, and a release is one read and one write. The occupancy memory (2048 words of
// 64 bits, one port read and one write) sets the pace. After reset a clearing pass over all 2048 words
// runs before commands are executed; configuration writes are accepted throughout.
module first_fit_core_wavelength_assigner_unit import ffwa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data
);
  logic [CORE_W:0] cores_r;
  logic [WAVE_W:0] waves_r;
  logic cmd_valid, cmd_ready, route_busy;
  cmd_t cmd;
  logic [HOP_IDX_W-1:0] hop_idx;
  logic [2*NODE_W-1:0] hop_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cores_r <= (CORE_W+1)'(8);
      waves_r <= (WAVE_W+1)'(64);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CORES: cores_r <= cfg_data[CORE_W:0];
        CFG_WAVES: waves_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ffwa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cmd_valid, .cmd_ready, .cmd,
    .route_busy, .hop_rd_idx(hop_idx), .hop_rd_data(hop_data)
  );
  ffwa_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .n_cores(cores_r), .n_waves(waves_r),
    .route_busy, .hop_rd_idx(hop_idx), .hop_rd_data(hop_data), .out_valid, .out_ready,
    .out_data
  );
endmodule

[hdl/ffwa_checker.sv]
// checker: port-level properties of the assigner
module ffwa_checker import ffwa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_GRANTED |->
      out_data.granted_core == '0 && out_data.granted_wavelength == '0)
    else $error("fields not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("beat dropped");
endmodule

bind first_fit_core_wavelength_assigner_unit ffwa_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);

[tb/sv/testbench.sv]
// testbench for the first-fit core and wavelength assigner: directed table, then random routes, releases and noise
module testbench import ffwa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int HOLD_CYCLES = 3000;
  localparam int IN_W = $bits(in_item_t);

  typedef struct packed {
    logic [4:0]            n;
    logic [15:0][7:0]      links;
    logic [CORE_W-1:0]     core;
    logic [WAVE_W-1:0]     wave;
  } lightpath_t;

  typedef struct packed {
    in_item_t  beat;
    logic      fixed;
    out_item_t res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, cfg_index;
  logic [6:0] cfg_data;
  in_item_t in_data;
  out_item_t out_data;

  logic [WORD_W-1:0] occupancy [DEPTH];
  logic [7:0] route_links [MAX_HOPS];
  int unsigned route_len;
  bit route_overflow;
  logic [3:0] cores_reg;
  logic [6:0] waves_reg;

  out_item_t grant_q[$];
  lightpath_t lightpaths[$];
  row_t rows[$];
  int errors;
  int idle_cycles;
  int burst_left;
  int unsigned rx_cnt;
  bit hold, hold_req;

  first_fit_core_wavelength_assigner_unit dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit assign_hop(in_item_t it, output out_item_t r);
    int unsigned ncores, nwaves, w;
    logic [WORD_W-1:0] mask, free;
    bit found;
    lightpath_t lp;
    r = '0;
    if (it.kind == KIND_RELEASE) begin
      occupancy[{it.from_node, it.to_node, it.release_core}][it.release_wavelength] = 1'b0;
      return 0;
    end
    if (route_len < MAX_HOPS) begin
      route_links[route_len] = {it.from_node, it.to_node};
      route_len++;
    end else begin
      route_overflow = 1;
    end
    if (!it.last_hop) return 0;
    if (route_overflow) begin
      r.status = ST_TOO_LONG;
    end else begin
      ncores = cores_reg > NUM_CORES ? NUM_CORES : cores_reg;
      nwaves = waves_reg > NUM_WAVELENGTHS ? NUM_WAVELENGTHS : waves_reg;
      mask = nwaves >= 64 ? '1 : (64'd1 << nwaves) - 64'd1;
      found = 0;
      r.status = ST_BLOCKED;
      for (int c = 0; c < ncores && !found; c++) begin
        free = mask;
        for (int h = 0; h < route_len; h++)
          free &= ~occupancy[{route_links[h], 3'(c)}];
        if (free != 0) begin
          found = 1;
          w = 0;
          while (!free[w]) w++;
          lp = '0;
          lp.n = 5'(route_len);
          lp.core = CORE_W'(c);
          lp.wave = WAVE_W'(w);
          for (int h = 0; h < route_len; h++) begin
            occupancy[{route_links[h], 3'(c)}][w] = 1'b1;
            lp.links[h] = route_links[h];
          end
          lightpaths = {lightpaths, lp};
          r.status = ST_GRANTED;
          r.granted_core = CORE_W'(c);
          r.granted_wavelength = WAVE_W'(w);
        end
      end
    end
    route_len = 0;
    route_overflow = 0;
    return 1;
  endfunction

  task automatic send(in_item_t it, bit fixed = 0, out_item_t want = '0);
    out_item_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (assign_hop(it, r)) grant_q = {grant_q, (fixed ? want : r)};
  endtask

  task automatic send_route(int len, int span);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it = IN_W'($urandom);
      it.kind = KIND_REQUEST;
      it.from_node = NODE_W'($urandom_range(0, span));
      it.to_node = NODE_W'($urandom_range(0, span));
      it.last_hop = (i == len - 1);
      send(it);
    end
  endtask

  task automatic free_lightpath();
    lightpath_t lp;
    in_item_t it;
    int k;
    k = $urandom_range(0, lightpaths.size() - 1);
    lp = lightpaths[k];
    lightpaths.delete(k);
    for (int h = 0; h < lp.n; h++) begin
      it = '0;
      it.kind = KIND_RELEASE;
      {it.from_node, it.to_node} = lp.links[h];
      it.last_hop = 1'($urandom);
      it.release_core = lp.core;
      it.release_wavelength = lp.wave;
      send(it);
    end
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CORES) cores_reg = val[3:0];
    else waves_reg = val;
  endtask

  task automatic add_row(logic kind, int from, int to, logic last, int rc, int rw,
                         logic fixed = 0, logic [1:0] st = ST_GRANTED, int gc = 0, int gw = 0);
    row_t r;
    r.beat = {kind, NODE_W'(from), NODE_W'(to), last, CORE_W'(rc), WAVE_W'(rw)};
    r.fixed = fixed;
    r.res = {st, CORE_W'(gc), WAVE_W'(gw)};
    rows = {rows, r};
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        report("beat with nothing expected, status", out_data.status, 0);
      end else begin
        if (out_data.status !== grant_q[0].status)
          report("status", out_data.status, grant_q[0].status);
        if (out_data.granted_core !== grant_q[0].granted_core)
          report("core", out_data.granted_core, grant_q[0].granted_core);
        if (out_data.granted_wavelength !== grant_q[0].granted_wavelength)
          report("wavelength", out_data.granted_wavelength, grant_q[0].granted_wavelength);
        void'(grant_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1;
    if (hold) out_ready <= 1'b0;
    else if (rx_cnt[8]) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  initial begin
    wait (hold_req);
    hold = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold = 0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int cfg_cores [6];
    int cfg_waves [6];
    int sent, pick;
    cfg_cores = '{1, 15, 0, 8, 2, 8};
    cfg_waves = '{1, 127, 64, 0, 3, 64};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CORES;
    cfg_data = '0;
    hold = 0;
    hold_req = 0;
    rx_cnt = 0;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    route_len = 0;
    route_overflow = 0;
    cores_reg = 4'd8;
    waves_reg = 7'd64;
    foreach (occupancy[i]) occupancy[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(KIND_REQUEST, 0, 1, 1, 0, 0, 1, ST_GRANTED, 0, 0);
    add_row(KIND_REQUEST, 0, 1, 1, 0, 0, 1, ST_GRANTED, 0, 1);
    add_row(KIND_RELEASE, 0, 1, 1, 0, 0);
    add_row(KIND_REQUEST, 0, 1, 1, 0, 0, 1, ST_GRANTED, 0, 0);
    add_row(KIND_REQUEST, 15, 15, 1, 7, 63, 1, ST_GRANTED, 0, 0);
    add_row(KIND_RELEASE, 15, 15, 0, 7, 63);
    add_row(KIND_REQUEST, 0, 1, 0, 0, 0);
    add_row(KIND_REQUEST, 1, 2, 1, 0, 0);
    for (int i = 0; i < 16; i++) add_row(KIND_REQUEST, 2, 3, 0, 0, 0);
    add_row(KIND_REQUEST, 2, 3, 1, 0, 0, 1, ST_TOO_LONG, 0, 0);
    foreach (rows[i]) send(rows[i].beat, rows[i].fixed, rows[i].res);

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_CORES, 7'(cfg_cores[p]));
      write_reg(CFG_WAVES, 7'(cfg_waves[p]));
      if (p == 5) hold_req = 1;
      sent = 0;
      while (sent < 100) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            send_route(16, 15);
            sent += 16;
          end else if (pick == 1) begin
            send_route(17 + $urandom_range(0, 2), 15);
            sent += 18;
          end else begin
            pick = $urandom_range(1, 4);
            send_route(pick, $urandom_range(0, 1) ? 3 : 15);
            sent += pick;
          end
        end else if (pick <= 7 && lightpaths.size() != 0) begin
          free_lightpath();
          sent += 2;
        end else begin
          in_data_noise: begin
            in_item_t it;
            it = IN_W'($urandom);
            send(it);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
